### src/mmcs_pkg.sv
// shared widths, types and constants for the min/max contrast stretch block
`default_nettype none

package mmcs_pkg;

    // pixel width and derived sizes
    localparam int PIXEL_BITS = 8;
    localparam int NUM_BITS   = 2 * PIXEL_BITS;
    localparam int CNT_BITS   = $clog2(PIXEL_BITS + 1);
    localparam int TDATA_BITS = ((PIXEL_BITS + 7) / 8) * 8;

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef logic [NUM_BITS-1:0]   num_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;

    localparam pixel_t PIX_MAX = {PIXEL_BITS{1'b1}};

    // request kinds carried in tuser bit 0
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    // handshake between the sequencer and the divider
    typedef struct packed {
        logic   start;
        num_t   num;
        pixel_t den;
    } div_req_t;

    typedef struct packed {
        logic   done;
        pixel_t quot;
    } div_rsp_t;

endpackage

`default_nettype wire

### src/mmcs_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit in a pixel
`default_nettype none

module mmcs_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mmcs_pkg::div_req_t req,
    output mmcs_pkg::div_rsp_t      rsp
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    mmcs_pkg::cnt_t     cnt_reg, cnt_next;
    mmcs_pkg::pixel_t   rem_reg, rem_next;
    mmcs_pkg::pixel_t   quot_reg, quot_next;
    mmcs_pkg::pixel_t   den_reg, den_next;

    logic [mmcs_pkg::PIXEL_BITS:0] trial;
    logic [mmcs_pkg::PIXEL_BITS:0] diff;

    // shared subtractor: shifted remainder minus divisor
    always_comb begin
        trial = {rem_reg, quot_reg[mmcs_pkg::PIXEL_BITS-1]};
        diff  = trial - {1'b0, den_reg};
    end

    // step sequencing
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = mmcs_pkg::cnt_t'(mmcs_pkg::PIXEL_BITS);
            // upper half is below the divisor, so only the low half needs steps
            rem_next  = req.num[mmcs_pkg::NUM_BITS-1:mmcs_pkg::PIXEL_BITS];
            quot_next = req.num[mmcs_pkg::PIXEL_BITS-1:0];
            den_next  = req.den;
        end else if (busy_reg) begin
            if (diff[mmcs_pkg::PIXEL_BITS]) begin
                rem_next  = trial[mmcs_pkg::PIXEL_BITS-1:0];
                quot_next = {quot_reg[mmcs_pkg::PIXEL_BITS-2:0], 1'b0};
            end else begin
                rem_next  = diff[mmcs_pkg::PIXEL_BITS-1:0];
                quot_next = {quot_reg[mmcs_pkg::PIXEL_BITS-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mmcs_pkg::cnt_t'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

`default_nettype wire

### src/min_max_contrast_stretch_core.sv
// top level of the min/max contrast stretch block: statistics, sequencer, output register
//
// Usage: stream pixels in on the s_ channel. s_tuser[0] selects the request kind
// (0 = scan, 1 = map), s_tuser[1] restarts the statistics on a scan request, and
// s_tdata carries the pixel byte. A scan request updates the running minimum and
// maximum in the cycle it is accepted and produces no result, so scan requests
// can arrive every cycle. A map request produces one result on the m_ channel:
// m_tdata is the stretched pixel and m_tuser is the flat flag (max equals min).
// A map request goes through a setup state, the bit-serial restoring divider (one
// quotient bit per cycle), a collect step for the quotient and the output register
// load before m_tvalid; results that need no division skip the divider. s_tready
// is low while a map request is in flight; the next request is taken as soon as
// the result sits in the output register, even if it has not been taken yet.
// If the receiver stalls, the finished result waits in the output register and a
// following map result holds in the sequencer until the register frees.
// Reset (aresetn low, synchronous) sets the minimum to 255, the maximum to 0 and
// empties the output register; map requests before any scan then give 0.
`default_nettype none

module min_max_contrast_stretch_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input channel
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [mmcs_pkg::TDATA_BITS-1:0] s_tdata, // pixel
    input  wire logic [1:0] s_tuser,                      // op, start_req
    // result channel
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [mmcs_pkg::TDATA_BITS-1:0] m_tdata,      // stretched
    output logic            m_tuser                       // flat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    mmcs_pkg::pixel_t low_reg, low_next;
    mmcs_pkg::pixel_t high_reg, high_next;
    mmcs_pkg::pixel_t px_reg, px_next;
    mmcs_pkg::pixel_t res_reg, res_next;
    logic             flat_reg, flat_next;
    logic             m_valid_reg, m_valid_next;
    mmcs_pkg::pixel_t m_data_reg, m_data_next;
    logic             m_flat_reg, m_flat_next;

    mmcs_pkg::div_req_t div_req;
    mmcs_pkg::div_rsp_t div_rsp;

    logic             s_fire;
    logic             s_op;
    logic             s_start;
    mmcs_pkg::pixel_t s_pixel;
    mmcs_pkg::pixel_t px_off;
    mmcs_pkg::pixel_t span;
    logic             out_free;

    assign s_op     = s_tuser[0];
    assign s_start  = s_tuser[1];
    assign s_pixel  = s_tdata[mmcs_pkg::PIXEL_BITS-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // offset and range for the division
    assign px_off = px_reg - low_reg;
    assign span   = high_reg - low_reg;

    mmcs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // sequencer and statistics
    always_comb begin
        state_next   = state_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        px_next      = px_reg;
        res_next     = res_reg;
        flat_next    = flat_reg;
        div_req.start = 1'b0;
        // numerator pix_max * offset as a shift and subtract
        div_req.num  = {px_off, {mmcs_pkg::PIXEL_BITS{1'b0}}}
                     - {{mmcs_pkg::PIXEL_BITS{1'b0}}, px_off};
        div_req.den  = span;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_op == mmcs_pkg::OP_SCAN) begin
                        if (s_start) begin
                            low_next  = s_pixel;
                            high_next = s_pixel;
                        end else begin
                            if (s_pixel < low_reg) begin
                                low_next = s_pixel;
                            end
                            if (s_pixel > high_reg) begin
                                high_next = s_pixel;
                            end
                        end
                    end else begin
                        px_next    = s_pixel;
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                flat_next = 1'b0;
                res_next  = '0;
                if (high_reg == low_reg) begin
                    flat_next  = 1'b1;
                    state_next = ST_OUT;
                end else if (high_reg < low_reg || px_reg <= low_reg) begin
                    state_next = ST_OUT;
                end else if (px_reg >= high_reg) begin
                    res_next   = mmcs_pkg::PIX_MAX;
                    state_next = ST_OUT;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    res_next   = div_rsp.quot;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_flat_next  = m_flat_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_valid_next = 1'b1;
            m_data_next  = res_reg;
            m_flat_next  = flat_reg;
        end
    end

    // control state and statistics
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            low_reg     <= mmcs_pkg::PIX_MAX;
            high_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        px_reg     <= px_next;
        res_reg    <= res_next;
        flat_reg   <= flat_next;
        m_data_reg <= m_data_next;
        m_flat_reg <= m_flat_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = mmcs_pkg::TDATA_BITS'(m_data_reg);
    assign m_tuser  = m_flat_reg;

    // flat results are always zero
    a_flat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_flat_reg |-> m_data_reg == '0)
        else $error("flat result with nonzero value");

    // a map request blocks the input the next cycle
    a_map_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_op == mmcs_pkg::OP_MAP |=> !s_tready)
        else $error("input ready right after a map request");

    // a restart sets both bounds to the pixel
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_op == mmcs_pkg::OP_SCAN && s_start |=> low_reg == high_reg)
        else $error("restart left unequal bounds");

    // divider completes only while the sequencer waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

endmodule

`default_nettype wire

### dv/min_max_contrast_stretch_core_test.sv
// self-checking testbench for the min/max contrast stretch core
`default_nettype none

module min_max_contrast_stretch_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    // one stretched pixel as it leaves the block
    typedef struct packed {
        mmcs_pkg::pixel_t stretched;
        logic             flat;
    } stretch_result_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [mmcs_pkg::TDATA_BITS-1:0] s_tdata  = '0;   // pixel
    logic [1:0]                      s_tuser  = '0;   // op, start_req
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [mmcs_pkg::TDATA_BITS-1:0] m_tdata;         // stretched
    logic                            m_tuser;         // flat

    // running statistics as the block should hold them
    mmcs_pkg::pixel_t run_min = mmcs_pkg::PIX_MAX;
    mmcs_pkg::pixel_t run_max = '0;

    stretch_result_t expected_pixels[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int scans_sent     = 0;
    int maps_sent      = 0;
    int pixels_checked = 0;

    min_max_contrast_stretch_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    // linear stretch of one pixel against the current min and max
    function automatic stretch_result_t stretch_pixel(mmcs_pkg::pixel_t px,
                                                      mmcs_pkg::pixel_t lo,
                                                      mmcs_pkg::pixel_t hi);
        stretch_result_t r;
        int              scaled;
        r = '0;
        if (hi == lo) begin
            r.flat = 1'b1;
        end else if (hi < lo) begin
            // no statistics yet: leave zero
        end else if (px <= lo) begin
            r.stretched = '0;
        end else if (px >= hi) begin
            r.stretched = mmcs_pkg::PIX_MAX;
        end else begin
            scaled = (int'(mmcs_pkg::PIX_MAX) * (int'(px) - int'(lo)))
                   / (int'(hi) - int'(lo));
            r.stretched = mmcs_pkg::pixel_t'(scaled);
        end
        return r;
    endfunction

    // scan request: restart or widen the running range
    function automatic void update_range(logic restart, mmcs_pkg::pixel_t px);
        if (restart) begin
            run_min = px;
            run_max = px;
        end else begin
            if (px < run_min) run_min = px;
            if (px > run_max) run_max = px;
        end
    endfunction

    // receiver stall pattern, changed on the falling edge
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each accepted result with the oldest expected pixel
    always @(posedge aclk) begin
        stretch_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual stretched %0d flat %0b",
                         $time, m_tdata[mmcs_pkg::PIXEL_BITS-1:0], m_tuser);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (m_tdata[mmcs_pkg::PIXEL_BITS-1:0] !== want.stretched) begin
                    $display("%0t: stretched mismatch, expected %0d actual %0d",
                             $time, want.stretched, m_tdata[mmcs_pkg::PIXEL_BITS-1:0]);
                    error_count++;
                end
                if (m_tuser !== want.flat) begin
                    $display("%0t: flat mismatch, expected %0b actual %0b",
                             $time, want.flat, m_tuser);
                    error_count++;
                end
            end
        end
    end

    // send one request, called and returning on a falling edge
    task automatic send_pixel(input logic op, input logic restart,
                              input mmcs_pkg::pixel_t px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = {restart, op};
        s_tdata  = px;
        do @(posedge aclk); while (!s_tready);
        if (op == mmcs_pkg::OP_MAP) begin
            expected_pixels.push_back(stretch_pixel(px, run_min, run_max));
            maps_sent++;
        end else begin
            update_range(restart, px);
            scans_sent++;
        end
        @(negedge aclk);
    endtask

    // hold off the sender until every result is back and the core is idle
    task automatic wait_results_drained();
        s_tvalid = 1'b0;
        while (expected_pixels.size() != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
    endtask

    // map requests before any scan give zero, start ignored on map
    task automatic test_after_reset();
        send_pixel(mmcs_pkg::OP_MAP, 1'b0, 8'd0);
        send_pixel(mmcs_pkg::OP_MAP, 1'b0, 8'd255);
        send_pixel(mmcs_pkg::OP_MAP, 1'b1, 8'd128);
    endtask

    // saturation below min and above max, values inside the range
    task automatic test_saturation();
        send_pixel(mmcs_pkg::OP_SCAN, 1'b1, 8'd100);
        send_pixel(mmcs_pkg::OP_SCAN, 1'b0, 8'd50);
        send_pixel(mmcs_pkg::OP_SCAN, 1'b0, 8'd200);
        send_pixel(mmcs_pkg::OP_MAP,  1'b0, 8'd0);
        send_pixel(mmcs_pkg::OP_MAP,  1'b0, 8'd50);
        send_pixel(mmcs_pkg::OP_MAP,  1'b0, 8'd51);
        send_pixel(mmcs_pkg::OP_MAP,  1'b0, 8'd125);
        send_pixel(mmcs_pkg::OP_MAP,  1'b0, 8'd199);
        send_pixel(mmcs_pkg::OP_MAP,  1'b0, 8'd200);
        send_pixel(mmcs_pkg::OP_MAP,  1'b0, 8'd255);
    endtask

    // min equals max raises flat
    task automatic test_flat_range();
        send_pixel(mmcs_pkg::OP_SCAN, 1'b1, 8'd77);
        send_pixel(mmcs_pkg::OP_SCAN, 1'b0, 8'd77);
        send_pixel(mmcs_pkg::OP_MAP,  1'b0, 8'd77);
        send_pixel(mmcs_pkg::OP_MAP,  1'b0, 8'd0);
        send_pixel(mmcs_pkg::OP_MAP,  1'b1, 8'd255);
    endtask

    // full 0..255 range, start on a map request leaves the range alone
    task automatic test_full_range();
        send_pixel(mmcs_pkg::OP_SCAN, 1'b1, 8'd255);
        send_pixel(mmcs_pkg::OP_SCAN, 1'b0, 8'd0);
        send_pixel(mmcs_pkg::OP_MAP,  1'b0, 8'd1);
        send_pixel(mmcs_pkg::OP_MAP,  1'b1, 8'd128);
        send_pixel(mmcs_pkg::OP_MAP,  1'b0, 8'd254);
    endtask

    // random pictures: scan pass over a band, then a map pass, plus noise
    task automatic test_random_pictures(input int idle_pct, input int stall_pct,
                                        input int n_items);
        int sent;
        int kind;
        int lo_b;
        int hi_b;
        int n_scan;
        int n_map;
        mmcs_pkg::pixel_t px;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(99);
            if (kind < 10) begin
                // stray request of any kind
                send_pixel(1'($urandom), 1'($urandom), mmcs_pkg::pixel_t'($urandom));
                sent++;
            end else begin
                lo_b = $urandom_range(255);
                case ($urandom_range(3))
                    0: begin
                        lo_b = 0;
                        hi_b = 255;
                    end
                    1: hi_b = lo_b + $urandom_range(3);
                    default: hi_b = lo_b + $urandom_range(255);
                endcase
                if (hi_b > 255) hi_b = 255;
                n_scan = $urandom_range(8, 1);
                for (int i = 0; i < n_scan; i++) begin
                    px = mmcs_pkg::pixel_t'($urandom_range(hi_b, lo_b));
                    // a few pictures carry on without a start
                    send_pixel(mmcs_pkg::OP_SCAN, (i == 0) && (kind >= 20), px);
                end
                n_map = $urandom_range(10, 1);
                for (int i = 0; i < n_map; i++) begin
                    if ($urandom_range(99) < 70)
                        px = mmcs_pkg::pixel_t'($urandom_range(hi_b, lo_b));
                    else
                        px = mmcs_pkg::pixel_t'($urandom);
                    send_pixel(mmcs_pkg::OP_MAP, 1'($urandom), px);
                end
                sent += n_scan + n_map;
            end
            if ($urandom_range(99) < 3) wait_results_drained();
        end
    endtask

    // main sequence
    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_after_reset();
        test_saturation();
        wait_results_drained();
        test_flat_range();
        test_full_range();
        wait_results_drained();

        test_random_pictures(0, 0, 175);
        test_random_pictures(84, 0, 175);
        test_random_pictures(0, 84, 175);
        test_random_pictures(15, 15, 175);

        wait_results_drained();
        $display("covered %0d scan and %0d map requests, %0d results compared",
                 scans_sent, maps_sent, pixels_checked);
        $display("phases: no idling, sender idle, receiver stall, both");
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // run time limit
    initial begin
        #2_000_000;
        $display("timeout at %0t", $time);
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
